>>> rtl/max_sum_3x3_window_finder_core_defines.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef MAX_SUM_3X3_WINDOW_FINDER_CORE_DEFINES_SVH
`define MAX_SUM_3X3_WINDOW_FINDER_CORE_DEFINES_SVH

// same-cycle implication
`define MSW_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define MSW_ASSERT_ALWAYS(name, cond, msg) `MSW_ASSERT_IMPL(name, 1'b1, cond, msg)

`endif

>>> rtl/msw_pkg.sv
`default_nettype none

package msw_pkg;

  localparam int ROW_W      = 10;
  localparam int POS_OUT_W  = 10;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WIN_SIZE   = 9;
  localparam int EMIT_CNT_W = 4;

  localparam logic [CNT_W-1:0] ROW_LIMIT   = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [EMIT_CNT_W-1:0] EMIT_NONE = 4'd0;
  localparam logic [EMIT_CNT_W-1:0] EMIT_ONE  = 4'd1;
  localparam logic [EMIT_CNT_W-1:0] EMIT_FULL = 4'd9;

endpackage

`default_nettype wire

>>> rtl/msw_if.sv
`default_nettype none

interface msw_elem_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface msw_result_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                                 valid;
  logic                                 ready;
  logic signed [ELEM_WIDTH-1:0]         window_value;
  logic [msw_pkg::ROW_W-1:0]            best_row;
  logic [msw_pkg::POS_OUT_W-1:0]        best_col;
  logic signed [ELEM_WIDTH+3:0]         best_sum;
  logic                                 no_window;
  logic                                 last;

  modport source (output valid, output window_value, output best_row, output best_col,
                  output best_sum, output no_window, output last, input ready);
  modport sink   (input valid, input window_value, input best_row, input best_col,
                  input best_sum, input no_window, input last, output ready);
endinterface

interface msw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [msw_pkg::CFG_IDX_W-1:0]  index;
  logic [msw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/msw_line_buf.sv
`default_nettype none

module msw_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    // same-address write in flight wins over the stored word
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/max_sum_3x3_window_finder_core.sv
// results: a frame's first result is valid once its final element has passed stage 2
// throughput: one element per cycle; a frame end waits only while the previous
//   frame's results are still being drained, at one result per cycle while ready is high
// line memory: one synchronous ram of MAX_COLS words, read at accept, written from stage 1
// reset: sizes return to 3x3, frame position and best window cleared, ram is not cleared
`default_nettype none

`include "max_sum_3x3_window_finder_core_defines.svh"

module max_sum_3x3_window_finder_core #(
  parameter int MAX_COLS   = 1024,
  parameter int ELEM_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  msw_cfg_if.sink       cfg_i,
  msw_elem_if.sink      elem_i,
  msw_result_if.source  result_o
);

  localparam int EW   = ELEM_WIDTH;
  localparam int CW   = $clog2(MAX_COLS);
  localparam int CCW  = (CW + 1 > msw_pkg::CNT_W) ? CW + 1 : msw_pkg::CNT_W;
  localparam int CSW  = EW + 2;
  localparam int SW   = EW + 4;
  localparam int RW   = msw_pkg::ROW_W;
  localparam int OW   = msw_pkg::POS_OUT_W;
  localparam int NW   = msw_pkg::WIN_SIZE;
  localparam int KW   = msw_pkg::CNT_W;
  localparam int ECW  = msw_pkg::EMIT_CNT_W;

  // configuration
  logic [KW-1:0] row_count_q, col_count_q;
  logic          cfg_fire, cfg_restart;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_restart = cfg_fire && ((cfg_i.index == msw_pkg::REG_ROW_COUNT) ||
                                    (cfg_i.index == msw_pkg::REG_COL_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= msw_pkg::COUNT_RESET;
      col_count_q <= msw_pkg::COUNT_RESET;
    end else if (cfg_fire) begin
      if (cfg_i.index == msw_pkg::REG_ROW_COUNT) begin
        row_count_q <= cfg_i.data;
      end
      if (cfg_i.index == msw_pkg::REG_COL_COUNT) begin
        col_count_q <= cfg_i.data;
      end
    end
  end

  logic [KW-1:0]  rows_eff;
  logic [CCW-1:0] cols_ext, cols_lim, cols_eff;

  assign cols_ext = CCW'(col_count_q);
  assign cols_lim = CCW'(MAX_COLS);

  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = KW'(1);
    end else if (row_count_q > msw_pkg::ROW_LIMIT) begin
      rows_eff = msw_pkg::ROW_LIMIT;
    end else begin
      rows_eff = row_count_q;
    end
    if (cols_ext == '0) begin
      cols_eff = CCW'(1);
    end else if (cols_ext > cols_lim) begin
      cols_eff = cols_lim;
    end else begin
      cols_eff = cols_ext;
    end
  end

  // pipeline control
  logic stall, advance, in_fire;

  assign advance      = !stall;
  assign elem_i.ready = advance;
  assign in_fire      = elem_i.valid && advance;

  // stage 0: frame position, line ram read
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q, col_m2;
  logic          last_row, last_col, frame_end, calc0;

  assign last_col  = (CCW'(col_q) + CCW'(1)) >= cols_eff;
  assign last_row  = (KW'(row_q) + KW'(1)) >= rows_eff;
  assign frame_end = last_row && last_col;
  assign calc0     = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign col_m2    = col_q - CW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_restart) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        row_q <= '0;
        col_q <= '0;
      end else if (last_col) begin
        row_q <= row_q + RW'(1);
        col_q <= '0;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // stage 1: ram data back, window shift, ram write
  logic                 s1_valid_q;
  logic signed [EW-1:0] s1_elem_q;
  logic [CW-1:0]        s1_col_q;
  logic                 s1_calc_q, s1_end_q;
  logic [RW-1:0]        s1_top_row_q;
  logic [OW-1:0]        s1_top_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_elem_q    <= elem_i.element;
      s1_col_q     <= col_q;
      s1_calc_q    <= calc0;
      s1_end_q     <= frame_end;
      s1_top_row_q <= row_q - RW'(2);
      s1_top_col_q <= OW'(col_m2);
    end
  end

  logic [2*EW-1:0]      lb_rd_data;
  logic signed [EW-1:0] up1, up2;
  logic                 s1_fire;

  assign s1_fire = s1_valid_q && advance;
  assign up1     = lb_rd_data[2*EW-1:EW];
  assign up2     = lb_rd_data[EW-1:0];

  msw_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * EW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({s1_elem_q, up1}),
    .rd_data_o (lb_rd_data)
  );

  logic signed [EW-1:0]  win_q [NW];
  logic signed [CSW-1:0] cs_q  [3];

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= up2;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= up1;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= s1_elem_q;
      cs_q[0]  <= cs_q[1];
      cs_q[1]  <= cs_q[2];
      cs_q[2]  <= CSW'(up2) + CSW'(up1) + CSW'(s1_elem_q);
    end
  end

  // stage 2: window sum, compare, best window update
  logic          s2_valid_q, s2_calc_q, s2_end_q;
  logic [RW-1:0] s2_top_row_q;
  logic [OW-1:0] s2_top_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_calc_q    <= s1_calc_q;
      s2_end_q     <= s1_end_q;
      s2_top_row_q <= s1_top_row_q;
      s2_top_col_q <= s1_top_col_q;
    end
  end

  logic signed [SW-1:0] win_sum, top_sum_q, nxt_sum;
  logic [RW-1:0]        top_row_q, nxt_row;
  logic [OW-1:0]        top_col_q, nxt_col;
  logic signed [EW-1:0] top_win_q [NW];
  logic signed [EW-1:0] nxt_win   [NW];
  logic                 have_q, have_after, take, s2_fire;

  assign s2_fire    = s2_valid_q && advance;
  assign win_sum    = SW'(cs_q[0]) + SW'(cs_q[1]) + SW'(cs_q[2]);
  assign take       = s2_calc_q && (!have_q || (win_sum > top_sum_q));
  assign have_after = have_q || take;
  assign nxt_sum    = take ? win_sum : top_sum_q;
  assign nxt_row    = take ? s2_top_row_q : top_row_q;
  assign nxt_col    = take ? s2_top_col_q : top_col_q;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      nxt_win[k] = take ? win_q[k] : top_win_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cfg_restart) begin
      have_q <= 1'b0;
    end else if (s2_fire) begin
      have_q <= s2_end_q ? 1'b0 : have_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && take) begin
      top_sum_q <= win_sum;
      top_row_q <= s2_top_row_q;
      top_col_q <= s2_top_col_q;
      for (int k = 0; k < NW; k++) begin
        top_win_q[k] <= win_q[k];
      end
    end
  end

  // result buffer: holds one frame's results and shifts them out
  logic [ECW-1:0]       eb_cnt_q;
  logic signed [EW-1:0] eb_win_q [NW];
  logic [RW-1:0]        eb_row_q;
  logic [OW-1:0]        eb_col_q;
  logic signed [SW-1:0] eb_sum_q;
  logic                 eb_nowin_q;
  logic                 eb_load, eb_free, out_fire;

  assign out_fire = result_o.valid && result_o.ready;
  assign eb_free  = (eb_cnt_q == msw_pkg::EMIT_NONE) ||
                    (result_o.ready && (eb_cnt_q == msw_pkg::EMIT_ONE));
  assign stall    = s2_valid_q && s2_end_q && !eb_free;
  assign eb_load  = s2_fire && s2_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eb_cnt_q <= msw_pkg::EMIT_NONE;
    end else if (eb_load) begin
      eb_cnt_q <= have_after ? msw_pkg::EMIT_FULL : msw_pkg::EMIT_ONE;
    end else if (out_fire) begin
      eb_cnt_q <= eb_cnt_q - ECW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eb_load) begin
      eb_nowin_q <= !have_after;
      eb_row_q   <= have_after ? nxt_row : '0;
      eb_col_q   <= have_after ? nxt_col : '0;
      eb_sum_q   <= have_after ? nxt_sum : '0;
      for (int k = 0; k < NW; k++) begin
        eb_win_q[k] <= have_after ? nxt_win[k] : '0;
      end
    end else if (out_fire) begin
      for (int k = 0; k < NW - 1; k++) begin
        eb_win_q[k] <= eb_win_q[k+1];
      end
    end
  end

  assign result_o.valid        = (eb_cnt_q != msw_pkg::EMIT_NONE);
  assign result_o.window_value = eb_win_q[0];
  assign result_o.best_row     = eb_row_q;
  assign result_o.best_col     = eb_col_q;
  assign result_o.best_sum     = eb_sum_q;
  assign result_o.no_window    = eb_nowin_q;
  assign result_o.last         = (eb_cnt_q == msw_pkg::EMIT_ONE);

  `MSW_ASSERT_ALWAYS(a_emit_cnt_range, eb_cnt_q <= msw_pkg::EMIT_FULL, "result count out of range")
  `MSW_ASSERT_NEXT(a_end_clears_best, s2_fire && s2_end_q, !have_q, "best window kept past frame end")
  `MSW_ASSERT_NEXT(a_stall_holds_end, stall, s2_valid_q && s2_end_q, "stalled frame end was lost")
  `MSW_ASSERT_IMPL(a_nowin_single, result_o.valid && eb_nowin_q, result_o.last, "no_window not last")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_COLS      = 1024;
  localparam int ELEM_W        = 16;
  localparam int SUM_W         = ELEM_W + 4;
  localparam int IDX_W         = msw_pkg::CFG_IDX_W;
  localparam int DATA_W        = msw_pkg::CFG_DATA_W;
  localparam int ROW_W         = msw_pkg::ROW_W;
  localparam int COL_W         = msw_pkg::POS_OUT_W;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ELEMS  = 410;
  localparam int PARTIAL_ELEMS = 40;
  localparam int N_DIRECTED    = 12;

  // indexes past the two real registers
  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_ELEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_WINDOW, CHK_NOWIN} check_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [SUM_W-1:0]  total;
    logic                     no_win;
    logic                     is_last;
  } win_beat_t;

  typedef struct {
    row_kind_e                kind;
    logic [IDX_W-1:0]         idx;
    logic [DATA_W-1:0]        data;
    int                       reps;
    logic signed [ELEM_W-1:0] elem;
    check_kind_e              chk;
    logic signed [ELEM_W-1:0] exp_value;
    int                       exp_total;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ELEM, msw_pkg::REG_ROW_COUNT, 11'd0,   9, 16'sh7FFF, CHK_WINDOW, 16'sh7FFF, 294903},
    '{ROW_CFG,  msw_pkg::REG_COL_COUNT, 11'd4,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    // all equal: earliest window wins the tie
    '{ROW_ELEM, msw_pkg::REG_ROW_COUNT, 11'd0,  12, 16'sh8000, CHK_WINDOW, 16'sh8000, -294912},
    '{ROW_CFG,  msw_pkg::REG_ROW_COUNT, 11'd1,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_CFG,  msw_pkg::REG_COL_COUNT, 11'd1,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_ELEM, msw_pkg::REG_ROW_COUNT, 11'd0,   1, 16'sd123,  CHK_NOWIN,  16'sh0000, 0},
    '{ROW_CFG,  msw_pkg::REG_ROW_COUNT, 11'd0,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_CFG,  msw_pkg::REG_COL_COUNT, 11'd0,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_ELEM, msw_pkg::REG_ROW_COUNT, 11'd0,   1, 16'shFFFF, CHK_NOWIN,  16'sh0000, 0},
    '{ROW_CFG,  REG_SPARE_2,            11'h7FF, 0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_CFG,  REG_SPARE_3,            11'd0,   0, 16'sh0000, CHK_MODEL,  16'sh0000, 0},
    '{ROW_ELEM, msw_pkg::REG_ROW_COUNT, 11'd0,   1, 16'sh5A5A, CHK_NOWIN,  16'sh0000, 0}
  };

  logic clk;
  logic rst_n;

  msw_cfg_if                           cfg_if ();
  msw_elem_if   #(.ELEM_WIDTH(ELEM_W)) elem_if ();
  msw_result_if #(.ELEM_WIDTH(ELEM_W)) res_if ();

  max_sum_3x3_window_finder_core #(
    .MAX_COLS  (MAX_COLS),
    .ELEM_WIDTH(ELEM_W)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .elem_i  (elem_if),
    .result_o(res_if)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // window tracker state
  logic [DATA_W-1:0]        row_cfg;
  logic [DATA_W-1:0]        col_cfg;
  logic signed [ELEM_W-1:0] ln_prev1 [MAX_COLS];
  logic signed [ELEM_W-1:0] ln_prev2 [MAX_COLS];
  logic signed [ELEM_W-1:0] win_taps [9];
  logic signed [ELEM_W-1:0] best_taps [9];
  int                       cur_row;
  int                       cur_col;
  int                       best_total;
  int                       best_top;
  int                       best_left;
  bit                       found_window;

  win_beat_t best_window_beats [$];

  int errs = 0;
  int quiet_cycles = 0;
  int burst_left;
  int rx_span;
  int rx_hold;
  rx_mode_e rx_mode;

  function automatic int eff_size(input logic [DATA_W-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    cur_row      = 0;
    cur_col      = 0;
    found_window = 1'b0;
  endfunction

  function automatic void clear_tracker();
    row_cfg    = msw_pkg::COUNT_RESET;
    col_cfg    = msw_pkg::COUNT_RESET;
    best_total = 0;
    best_top   = 0;
    best_left  = 0;
    for (int k = 0; k < MAX_COLS; k++) begin
      ln_prev1[k] = '0;
      ln_prev2[k] = '0;
    end
    for (int k = 0; k < 9; k++) begin
      win_taps[k]  = '0;
      best_taps[k] = '0;
    end
    restart_frame();
  endfunction

  function automatic void apply_reg_write(input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] val);
    if (idx == msw_pkg::REG_ROW_COUNT) begin
      row_cfg = val;
      restart_frame();
    end else if (idx == msw_pkg::REG_COL_COUNT) begin
      col_cfg = val;
      restart_frame();
    end
  endfunction

  function automatic void track_best_window(input logic signed [ELEM_W-1:0] e,
                                            input bit record);
    int rows;
    int cols;
    int ci;
    int acc;
    win_beat_t beat;
    rows = eff_size(row_cfg, int'(msw_pkg::ROW_LIMIT));
    cols = eff_size(col_cfg, MAX_COLS);
    ci   = cur_col % MAX_COLS;
    for (int k = 0; k < 3; k++) begin
      win_taps[k*3]   = win_taps[k*3+1];
      win_taps[k*3+1] = win_taps[k*3+2];
    end
    win_taps[2]  = ln_prev2[ci];
    win_taps[5]  = ln_prev1[ci];
    win_taps[8]  = e;
    ln_prev2[ci] = ln_prev1[ci];
    ln_prev1[ci] = e;

    if (cur_row >= 2 && cur_col >= 2) begin
      acc = 0;
      for (int k = 0; k < 9; k++) acc += int'(win_taps[k]);
      if (!found_window || acc > best_total) begin
        found_window = 1'b1;
        best_total   = acc;
        best_top     = cur_row - 2;
        best_left    = cur_col - 2;
        best_taps    = win_taps;
      end
    end

    if (cur_row + 1 >= rows && cur_col + 1 >= cols) begin
      if (record) begin
        if (found_window) begin
          for (int k = 0; k < 9; k++) begin
            beat.value   = best_taps[k];
            beat.row     = ROW_W'(best_top);
            beat.col     = COL_W'(best_left);
            beat.total   = SUM_W'(best_total);
            beat.no_win  = 1'b0;
            beat.is_last = (k == 8);
            best_window_beats.push_back(beat);
          end
        end else begin
          beat         = '0;
          beat.no_win  = 1'b1;
          beat.is_last = 1'b1;
          best_window_beats.push_back(beat);
        end
      end
      restart_frame();
    end else if (cur_col + 1 >= cols) begin
      cur_col = 0;
      cur_row = cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endfunction

  function automatic void push_typed(input stim_row_t r);
    win_beat_t beat;
    beat = '0;
    if (r.chk == CHK_NOWIN) begin
      beat.no_win  = 1'b1;
      beat.is_last = 1'b1;
      best_window_beats.push_back(beat);
    end else begin
      for (int k = 0; k < 9; k++) begin
        beat.value   = r.exp_value;
        beat.total   = SUM_W'(r.exp_total);
        beat.is_last = (k == 8);
        best_window_beats.push_back(beat);
      end
    end
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg_write(idx, val);
  endtask

  task automatic send_element(input logic signed [ELEM_W-1:0] e, input bit record);
    elem_if.valid   <= 1'b1;
    elem_if.element <= e;
    @(posedge clk);
    while (!elem_if.ready) @(posedge clk);
    track_best_window(e, record);
  endtask

  // bursts of transfers separated by random gaps
  task automatic sender_pace();
    int gap;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        elem_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    elem_if.valid <= 1'b0;
    while (best_window_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame();
    int len;
    int style;
    logic signed [ELEM_W-1:0] v;
    len   = eff_size(row_cfg, int'(msw_pkg::ROW_LIMIT)) * eff_size(col_cfg, MAX_COLS);
    style = $urandom_range(0, 5);
    for (int n = 0; n < len; n++) begin
      case (style)
        3: v = ELEM_W'(int'($urandom_range(0, 4)) - 2);
        4: begin
          case ($urandom_range(0, 3))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = 16'shFFFF;
            default: v = 16'sh0000;
          endcase
        end
        5: v = (n == 0) ? ELEM_W'($urandom()) : v;
        default: v = ELEM_W'($urandom());
      endcase
      send_element(v, 1'b1);
      sender_pace();
    end
  endtask

  // result receiver with its own stall pattern
  initial begin
    res_if.ready <= 1'b0;
    rx_span = 0;
    rx_hold = 0;
    rx_mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (rx_span == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_span = $urandom_range(20, 120);
      end
      rx_span = rx_span - 1;
      case (rx_mode)
        RX_OPEN: res_if.ready <= 1'b1;
        RX_COIN: res_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            res_if.ready <= 1'b0;
          end else if ($urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(0, 7);
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    win_beat_t got;
    win_beat_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.window_value, res_if.best_row, res_if.best_col, res_if.best_sum,
              res_if.no_window, res_if.last};
      if (best_window_beats.size() == 0) begin
        errs = errs + 1;
        if (errs <= 10)
          $display("unexpected result transfer: v=%0d r=%0d c=%0d s=%0d nw=%0b l=%0b",
                   got.value, got.row, got.col, got.total, got.no_win, got.is_last);
      end else begin
        want = best_window_beats.pop_front();
        if (got !== want) begin
          errs = errs + 1;
          if (errs <= 10)
            $display({"result mismatch: exp v=%0d r=%0d c=%0d s=%0d nw=%0b l=%0b, ",
                      "act v=%0d r=%0d c=%0d s=%0d nw=%0b l=%0b"},
                     want.value, want.row, want.col, want.total, want.no_win, want.is_last,
                     got.value, got.row, got.col, got.total, got.no_win, got.is_last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("max_sum_3x3_window_finder_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int random_elems;
    int phase;
    int frames;
    bit big;
    bit open_frame;
    bit reconfig;
    logic [DATA_W-1:0] rows_w;
    logic [DATA_W-1:0] cols_w;

    burst_left      = 1;
    rst_n           <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    elem_if.valid   <= 1'b0;
    elem_if.element <= '0;
    clear_tracker();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i > 0 && directed_rows[i-1].kind == ROW_ELEM) wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (i == N_DIRECTED - 1 || directed_rows[i+1].kind != ROW_CFG)
          cfg_if.valid <= 1'b0;
      end else begin
        for (int n = 0; n < directed_rows[i].reps; n++) begin
          send_element(directed_rows[i].elem, directed_rows[i].chk == CHK_MODEL);
          if (n == directed_rows[i].reps - 1 && directed_rows[i].chk != CHK_MODEL)
            push_typed(directed_rows[i]);
          sender_pace();
        end
      end
    end

    random_elems = 0;
    phase        = 0;
    open_frame   = 1'b0;
    while (random_elems < RANDOM_ELEMS) begin
      wait_drained();
      big = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          rows_w = DATA_W'($urandom_range(0, 2));
          cols_w = DATA_W'($urandom_range(0, 6));
        end
        1: begin
          rows_w = DATA_W'($urandom_range(0, 6));
          cols_w = DATA_W'($urandom_range(0, 2));
        end
        9: begin
          rows_w = DATA_W'($urandom_range(3, 10));
          cols_w = DATA_W'($urandom_range(3, 16));
        end
        default: begin
          rows_w = DATA_W'($urandom_range(3, 6));
          cols_w = DATA_W'($urandom_range(3, 8));
        end
      endcase
      // oversized row and column counts, saturated instead of wrapped
      if (phase == 2) begin
        rows_w = 11'd1026;
        cols_w = 11'd5;
        big    = 1'b1;
      end else if (phase == 5) begin
        rows_w = 11'd4;
        cols_w = 11'd1027;
        big    = 1'b1;
      end
      reconfig = big || open_frame || phase == 0 || $urandom_range(0, 3) != 0;
      if (reconfig) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(msw_pkg::REG_ROW_COUNT, rows_w);
          write_reg(msw_pkg::REG_COL_COUNT, cols_w);
        end else begin
          write_reg(msw_pkg::REG_COL_COUNT, cols_w);
          write_reg(msw_pkg::REG_ROW_COUNT, rows_w);
        end
        cfg_if.valid <= 1'b0;
      end
      if (big) begin
        // only the head of the frame, the next register write restarts it
        for (int n = 0; n < PARTIAL_ELEMS; n++) begin
          send_element(ELEM_W'($urandom()), 1'b1);
          sender_pace();
        end
        random_elems += PARTIAL_ELEMS;
      end else begin
        frames = $urandom_range(1, 3);
        repeat (frames) begin
          send_frame();
          random_elems += eff_size(row_cfg, int'(msw_pkg::ROW_LIMIT)) *
                          eff_size(col_cfg, MAX_COLS);
        end
      end
      open_frame = big;
      phase = phase + 1;
    end

    wait_drained();
    if (errs == 0) begin
      $display("max_sum_3x3_window_finder_core: match");
    end else begin
      $display("max_sum_3x3_window_finder_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/msw_pkg.sv
rtl/msw_if.sv
rtl/msw_line_buf.sv
rtl/max_sum_3x3_window_finder_core.sv
tb/tb_top.sv
